[rtl/schk_pkg.sv]
// Package for the schema keyword recogniser: result codes, automaton tables.
// Transition, leaf and accept functions are used by schema_keyword_recognizer.
// No dependencies.
package schk_pkg;

  localparam int StateW = 7;
  localparam int IdW = 5;

  typedef enum logic [IdW-1:0] {
    KW_TYPE, KW_EQ, KW_NE, KW_LT, KW_GT, KW_LE, KW_GE,
    KW_LEN_EQ, KW_LEN_NE, KW_LEN_LT, KW_LEN_GT, KW_LEN_LE, KW_LEN_GE,
    KW_REF, KW_REGEX, KW_TEST, KW_ITEMS, KW_OPT_ITEMS, KW_ALL_ITEMS, KW_ALL_KEYS,
    KW_IN, KW_NONE
  } keyword_t;

  localparam logic [StateW-1:0] START_STATE = 7'd0;
  localparam logic [StateW-1:0] LAST_STATE = 7'd64;
  localparam logic [IdW-1:0] NO_KEYWORD = KW_NONE;
  localparam logic [7:0] END_BYTE = 8'd0;

  typedef struct packed {
    logic hit;
    logic [StateW-1:0] to;
  } trans_t;

  function automatic trans_t edge_of(input logic [StateW-1:0] s, input logic [7:0] b);
    trans_t t;
    t.hit = 1'b1;
    t.to = START_STATE;
    case (s)
      7'd0: begin
        case (b)
          8'd33: t.to = 7'd1;
          8'd60: t.to = 7'd2;
          8'd61: t.to = 7'd3;
          8'd62: t.to = 7'd4;
          8'd97: t.to = 7'd5;
          8'd105: t.to = 7'd6;
          8'd108: t.to = 7'd7;
          8'd111: t.to = 7'd8;
          8'd114: t.to = 7'd9;
          8'd116: t.to = 7'd10;
          default: t.hit = 1'b0;
        endcase
      end
      7'd1, 7'd2, 7'd3, 7'd4: begin
        t.hit = (b == 8'd61);
        t.to = s + 7'd10;
      end
      7'd5: begin
        t.hit = (b == 8'd108);
        t.to = 7'd15;
      end
      7'd6: begin
        t.hit = (b == 8'd110) || (b == 8'd116);
        t.to = (b == 8'd110) ? 7'd16 : 7'd17;
      end
      7'd7: begin
        t.hit = (b == 8'd101);
        t.to = 7'd18;
      end
      7'd8: begin
        t.hit = (b == 8'd112);
        t.to = 7'd19;
      end
      7'd9: begin
        t.hit = (b == 8'd101);
        t.to = 7'd20;
      end
      7'd10: begin
        t.hit = (b == 8'd101) || (b == 8'd121);
        t.to = (b == 8'd101) ? 7'd21 : 7'd22;
      end
      7'd15: begin
        t.hit = (b == 8'd108);
        t.to = 7'd23;
      end
      7'd17: begin
        t.hit = (b == 8'd101);
        t.to = 7'd24;
      end
      7'd18: begin
        t.hit = (b == 8'd110);
        t.to = 7'd25;
      end
      7'd19: begin
        t.hit = (b == 8'd116);
        t.to = 7'd26;
      end
      7'd20: begin
        t.hit = (b == 8'd102) || (b == 8'd103);
        t.to = (b == 8'd102) ? 7'd27 : 7'd28;
      end
      7'd21: begin
        t.hit = (b == 8'd115);
        t.to = 7'd29;
      end
      7'd22: begin
        t.hit = (b == 8'd112);
        t.to = 7'd30;
      end
      7'd23: begin
        t.hit = (b == 8'd45);
        t.to = 7'd31;
      end
      7'd24: begin
        t.hit = (b == 8'd109);
        t.to = 7'd32;
      end
      7'd25: begin
        t.hit = (b == 8'd103);
        t.to = 7'd33;
      end
      7'd26: begin
        t.hit = (b == 8'd45);
        t.to = 7'd34;
      end
      7'd28: begin
        t.hit = (b == 8'd101);
        t.to = 7'd35;
      end
      7'd29: begin
        t.hit = (b == 8'd116);
        t.to = 7'd36;
      end
      7'd30: begin
        t.hit = (b == 8'd101);
        t.to = 7'd37;
      end
      7'd31: begin
        t.hit = (b == 8'd105) || (b == 8'd107);
        t.to = (b == 8'd105) ? 7'd38 : 7'd39;
      end
      7'd32: begin
        t.hit = (b == 8'd115);
        t.to = 7'd40;
      end
      7'd33: begin
        t.hit = (b == 8'd116);
        t.to = 7'd41;
      end
      7'd34: begin
        t.hit = (b == 8'd105);
        t.to = 7'd42;
      end
      7'd35: begin
        t.hit = (b == 8'd120);
        t.to = 7'd43;
      end
      7'd38: begin
        t.hit = (b == 8'd116);
        t.to = 7'd44;
      end
      7'd39: begin
        t.hit = (b == 8'd101);
        t.to = 7'd45;
      end
      7'd41: begin
        t.hit = (b == 8'd104);
        t.to = 7'd46;
      end
      7'd42: begin
        t.hit = (b == 8'd116);
        t.to = 7'd47;
      end
      7'd44: begin
        t.hit = (b == 8'd101);
        t.to = 7'd48;
      end
      7'd45: begin
        t.hit = (b == 8'd121);
        t.to = 7'd49;
      end
      7'd46: begin
        t.hit = (b == 8'd32);
        t.to = 7'd50;
      end
      7'd47: begin
        t.hit = (b == 8'd101);
        t.to = 7'd51;
      end
      7'd48: begin
        t.hit = (b == 8'd109);
        t.to = 7'd52;
      end
      7'd49: begin
        t.hit = (b == 8'd115);
        t.to = 7'd53;
      end
      7'd50: begin
        case (b)
          8'd33: t.to = 7'd54;
          8'd60: t.to = 7'd55;
          8'd61: t.to = 7'd56;
          8'd62: t.to = 7'd57;
          default: t.hit = 1'b0;
        endcase
      end
      7'd51: begin
        t.hit = (b == 8'd109);
        t.to = 7'd58;
      end
      7'd52: begin
        t.hit = (b == 8'd115);
        t.to = 7'd59;
      end
      7'd54, 7'd55, 7'd56, 7'd57: begin
        t.hit = (b == 8'd61);
        t.to = s + 7'd6;
      end
      7'd58: begin
        t.hit = (b == 8'd115);
        t.to = 7'd64;
      end
      default: t.hit = 1'b0;
    endcase
    return t;
  endfunction

  function automatic logic is_leaf(input logic [StateW-1:0] s);
    logic r;
    case (s)
      7'd11, 7'd12, 7'd13, 7'd14, 7'd16, 7'd27, 7'd36, 7'd37, 7'd40, 7'd43,
      7'd53, 7'd59, 7'd60, 7'd61, 7'd62, 7'd63, 7'd64: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [IdW-1:0] accept_of(input logic [StateW-1:0] s);
    logic [IdW-1:0] r;
    case (s)
      7'd2: r = KW_LT;
      7'd4: r = KW_GT;
      7'd11: r = KW_NE;
      7'd12: r = KW_LE;
      7'd13: r = KW_EQ;
      7'd14: r = KW_GE;
      7'd16: r = KW_IN;
      7'd27: r = KW_REF;
      7'd36: r = KW_TEST;
      7'd37: r = KW_TYPE;
      7'd40: r = KW_ITEMS;
      7'd43: r = KW_REGEX;
      7'd53: r = KW_ALL_KEYS;
      7'd55: r = KW_LEN_LT;
      7'd57: r = KW_LEN_GT;
      7'd59: r = KW_ALL_ITEMS;
      7'd60: r = KW_LEN_NE;
      7'd61: r = KW_LEN_LE;
      7'd62: r = KW_LEN_EQ;
      7'd63: r = KW_LEN_GE;
      7'd64: r = KW_OPT_ITEMS;
      default: r = NO_KEYWORD;
    endcase
    return r;
  endfunction

endpackage

[rtl/schema_keyword_recognizer.sv]
// Top level of the schema keyword recogniser: input register, automaton step, result register.
// Depends on schk_pkg for the transition, leaf and accept tables.
//
//   channel  handshake          payload
//   in       in_valid/in_stall  char_byte[7:0]
//   out      out_valid/out_stall keyword_id[4:0], matched
//
// One byte per cycle while the result side does not stall: a byte is held in the input register,
// then the automaton state register takes one transition and the result register loads.
// Reset (rst, synchronous) returns the automaton to its start state and empties both registers.
// A stalled result holds the automaton; the input register then stalls its side.
module schema_keyword_recognizer (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               char_byte,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [schk_pkg::IdW-1:0] keyword_id,
  output logic                     matched
);
  import schk_pkg::*;

  logic              in_q_valid;
  logic [7:0]        in_q_byte;
  logic [StateW-1:0] state;
  logic [StateW-1:0] state_next;
  logic              skipping;
  logic              skipping_next;
  logic              advance;
  logic              emit;
  logic [IdW-1:0]    emit_id;
  logic [StateW-1:0] cur;
  trans_t            tr;

  assign advance  = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;
  assign cur      = (state > LAST_STATE) ? START_STATE : state;
  assign tr       = edge_of(cur, in_q_byte);

  always_comb begin
    state_next    = state;
    skipping_next = skipping;
    emit          = 1'b0;
    emit_id       = NO_KEYWORD;
    if (skipping) begin
      if (in_q_byte == END_BYTE) begin
        skipping_next = 1'b0;
        state_next    = START_STATE;
      end
    end else if (tr.hit) begin
      if (is_leaf(tr.to)) begin
        emit          = 1'b1;
        emit_id       = accept_of(tr.to);
        state_next    = START_STATE;
        skipping_next = 1'b1;
      end else begin
        state_next = tr.to;
      end
    end else begin
      emit          = 1'b1;
      emit_id       = accept_of(cur);
      state_next    = START_STATE;
      skipping_next = (in_q_byte != END_BYTE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      state      <= START_STATE;
      skipping   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_q_valid <= in_valid;
      end
      if (advance) begin
        state     <= state_next;
        skipping  <= skipping_next;
        out_valid <= emit;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_q_byte <= char_byte;
    end
    if (advance && emit) begin
      keyword_id <= emit_id;
      matched    <= (emit_id != NO_KEYWORD);
    end
  end

`ifndef SYNTH
  a_skip_at_start: assert property (@(posedge clk) disable iff (rst)
    skipping |-> (state == START_STATE))
    else $error("skipping outside start state");

  a_state_range: assert property (@(posedge clk) disable iff (rst)
    state <= LAST_STATE)
    else $error("automaton state out of range");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> in_q_valid && $stable(in_q_byte))
    else $error("input register lost a stalled item");

  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    advance && emit |=> out_valid && (matched == (keyword_id != NO_KEYWORD)))
    else $error("result not loaded");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state) && $stable(skipping))
    else $error("automaton moved without an item");
`endif

endmodule

[test/tb_top.sv]
// Self-checking bench for schema_keyword_recognizer: streams zero-terminated names
// byte by byte and checks each keyword verdict against a prefix-matching predictor.
// Depends on schk_pkg and the schema_keyword_recognizer RTL only.
`timescale 1ns / 1ps

module tb_top;
  import schk_pkg::*;

  localparam int KW_COUNT = 21;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    keyword_t id;
    logic     hit;
  } verdict_t;

  typedef struct {
    logic [7:0] b;
    int         gap;
    bit         drain;
  } feed_item_t;

  string keyword_text [0:KW_COUNT-1] = '{
    "type", "==", "!=", "<", ">", "<=", ">=",
    "length ==", "length !=", "length <", "length >", "length <=", "length >=",
    "ref", "regex", "test", "items", "opt-items", "all-items", "all-keys", "in"
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] char_byte = 8'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IdW-1:0] keyword_id;
  logic matched;

  feed_item_t feed[$];
  verdict_t verdicts_due[$];
  string name_prefix = "";
  bit skip_to_end = 1'b0;
  logic in_fire = 1'b0;
  int cycle = 0;
  int errors = 0;
  int stall_left = 0;
  bit long_hold_done = 1'b0;
  int bytes_queued = 0;

  schema_keyword_recognizer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .char_byte(char_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .keyword_id(keyword_id),
    .matched(matched)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic keyword_t keyword_named(input string p);
    keyword_t id;
    id = KW_NONE;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (keyword_text[k] == p) id = keyword_t'(k);
    end
    return id;
  endfunction

  // reach: some keyword starts with p; longer: some keyword strictly extends p
  function automatic void probe_prefix(input string p, output bit reach, output bit longer);
    reach = 1'b0;
    longer = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (keyword_text[k].len() >= p.len() &&
          keyword_text[k].substr(0, p.len() - 1) == p) begin
        reach = 1'b1;
        if (keyword_text[k].len() > p.len()) longer = 1'b1;
      end
    end
  endfunction

  function automatic bit predict_byte(input logic [7:0] b, output verdict_t v);
    string ext;
    bit reach, longer;
    keyword_t id;
    v.id = KW_NONE;
    v.hit = 1'b0;
    if (skip_to_end) begin
      if (b == END_BYTE) skip_to_end = 1'b0;
      return 1'b0;
    end
    if (b != END_BYTE) begin
      ext = {name_prefix, " "};
      ext.putc(ext.len() - 1, b);
      probe_prefix(ext, reach, longer);
      if (reach && longer) begin
        name_prefix = ext;
        return 1'b0;
      end
      if (reach) begin
        id = keyword_named(ext);
        v.id = id;
        v.hit = (id != KW_NONE);
        name_prefix = "";
        skip_to_end = 1'b1;
        return 1'b1;
      end
    end
    id = keyword_named(name_prefix);
    v.id = id;
    v.hit = (id != KW_NONE);
    name_prefix = "";
    skip_to_end = (b != END_BYTE);
    return 1'b1;
  endfunction

  function automatic int draw_gap(input bit busy);
    int r;
    r = $urandom_range(0, 99);
    if (busy || r < 55) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit busy);
    feed_item_t it;
    it.b = b;
    it.gap = draw_gap(busy);
    it.drain = 1'b0;
    feed.push_back(it);
    bytes_queued++;
  endtask

  task automatic push_name(input string s, input bit busy);
    for (int i = 0; i < s.len(); i++) push_byte(s.getc(i), busy);
    push_byte(END_BYTE, busy);
  endtask

  task automatic push_drain();
    feed_item_t it;
    it.b = END_BYTE;
    it.gap = 0;
    it.drain = 1'b1;
    feed.push_back(it);
  endtask

  task automatic build_random_names();
    string s;
    int kind, names, cut, pos, tail;
    bit busy;
    names = 0;
    while (bytes_queued < 520) begin
      kind = $urandom_range(0, 99);
      busy = ($urandom_range(0, 9) < 2);
      s = keyword_text[$urandom_range(0, KW_COUNT - 1)];
      if (kind < 60) begin
        if ($urandom_range(0, 9) < 3) begin
          tail = $urandom_range(1, 3);
          for (int i = 0; i < tail; i++) begin
            s = {s, " "};
            s.putc(s.len() - 1, byte'($urandom_range(1, 255)));
          end
        end
      end else if (kind < 75) begin
        cut = $urandom_range(0, s.len() - 1);
        s = s.substr(0, cut - 1);
      end else if (kind < 85) begin
        pos = $urandom_range(0, s.len() - 1);
        s.putc(pos, byte'($urandom_range(1, 255)));
      end else begin
        s = "";
        tail = $urandom_range(0, 5);
        for (int i = 0; i < tail; i++) begin
          s = {s, " "};
          s.putc(s.len() - 1, byte'($urandom_range(1, 255)));
        end
      end
      push_name(s, busy);
      names++;
      if (names == 60 || names == 150) push_drain();
    end
  endtask

  initial begin
    push_name("", 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(END_BYTE, 1'b0);
    push_name("<", 1'b0);
    push_byte(8'd60, 1'b0);
    push_byte(8'd1, 1'b0);
    push_byte(END_BYTE, 1'b0);
    push_name("in", 1'b0);
    push_name("t", 1'b0);
    push_name("==", 1'b0);
    push_name("length >", 1'b0);
    push_drain();
    build_random_names();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (feed.size() != 0 || in_valid || verdicts_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // driver: hold a stalled item, otherwise advance through the feed
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (feed.size() == 0) begin
        in_valid <= 1'b0;
      end else if (feed[0].drain) begin
        in_valid <= 1'b0;
        if (verdicts_due.size() == 0) void'(feed.pop_front());
      end else if (feed[0].gap > 0) begin
        in_valid <= 1'b0;
        feed[0].gap = feed[0].gap - 1;
      end else begin
        char_byte <= feed[0].b;
        in_valid <= 1'b1;
        void'(feed.pop_front());
      end
    end
  end

  // receiver: random stalls, one long hold-off, and quiet stretches
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!long_hold_done && cycle >= 300) begin
      out_stall <= 1'b1;
      stall_left <= 160;
      long_hold_done <= 1'b1;
    end else if (((cycle / 400) % 3) == 2) begin
      out_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:69]: out_stall <= 1'b0;
        [70:96]: begin
          out_stall <= 1'b1;
          stall_left <= $urandom_range(0, 2);
        end
        default: begin
          out_stall <= 1'b1;
          stall_left <= $urandom_range(10, 30);
        end
      endcase
    end
  end

  always @(posedge clk) begin : monitor
    verdict_t v, want;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        if (predict_byte(char_byte, v)) verdicts_due.push_back(v);
      end
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          $error("unexpected result: keyword_id=%0d matched=%0b", keyword_id, matched);
          errors++;
        end else begin
          want = verdicts_due.pop_front();
          if (keyword_id !== want.id) begin
            $error("keyword_id: expected %0d, got %0d", want.id, keyword_id);
            errors++;
          end
          if (matched !== want.hit) begin
            $error("matched: expected %0b, got %0b", want.hit, matched);
            errors++;
          end
        end
      end
    end
  end

endmodule
